/* rtl/bde_pkg.sv */
// bde_pkg: operation codes, status codes, field widths and the cell command
// struct shared by the deque cell and the deque top level
// no dependencies
`timescale 1ns / 1ps

package bde_pkg;

    // fixed widths of the transaction fields
    localparam int FIELD_WIDTH = 32;
    localparam int FUNC_WIDTH = 2;
    localparam int STATUS_WIDTH = 2;
    localparam int COUNT_OUT_WIDTH = 7;

    // operation codes
    localparam logic [FUNC_WIDTH-1:0] FUNC_PUSH_FRONT = 2'd0;
    localparam logic [FUNC_WIDTH-1:0] FUNC_PUSH_BACK  = 2'd1;
    localparam logic [FUNC_WIDTH-1:0] FUNC_POP_FRONT  = 2'd2;
    localparam logic [FUNC_WIDTH-1:0] FUNC_ROTATE     = 2'd3;

    // status codes
    localparam logic [STATUS_WIDTH-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_WIDTH-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_WIDTH-1:0] ST_FULL  = 2'd2;

    // broadcast command to every cell, already qualified by ok status
    typedef struct packed {
        logic push_front;
        logic push_back;
        logic pop_front;
        logic rotate;
    } cell_cmd_t;

endpackage

/* rtl/bde_cell.sv */
// bde_cell: one storage cell of the deque chain, holding the entry at a
// fixed position from the front; shifts with its neighbors
// depends on bde_pkg
`timescale 1ns / 1ps

module bde_cell #(
    parameter int INDEX = 0,
    parameter int SW = 32,
    parameter int CW = 7
) (
    input  logic             clk,
    input  bde_pkg::cell_cmd_t cmd,
    input  logic [CW-1:0]    count,
    input  logic [SW-1:0]    push_val,
    input  logic [SW-1:0]    left_val,
    input  logic [SW-1:0]    right_val,
    input  logic [SW-1:0]    front_val,
    output logic [SW-1:0]    q
);
    import bde_pkg::*;

    logic [SW-1:0] entry_reg;
    logic [SW-1:0] entry_next;
    logic          at_tail;
    logic          at_last;

    // position of this cell relative to the current fill level
    assign at_tail = (count == CW'(INDEX));
    assign at_last = (count == CW'(INDEX + 1));

    // next entry value from the broadcast command
    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.push_front)
        begin
            entry_next = left_val;
        end
        else if (cmd.push_back)
        begin
            if (at_tail)
            begin
                entry_next = push_val;
            end
        end
        else if (cmd.pop_front)
        begin
            entry_next = right_val;
        end
        else if (cmd.rotate)
        begin
            entry_next = at_last ? front_val : right_val;
        end
    end

    // payload register, no reset
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign q = entry_reg;

endmodule

/* rtl/bounded_deque_engine.sv */
// bounded_deque_engine: top level of a bounded double-ended queue built as
// a chain of shifting cells, with result registers and the command port
// depends on bde_pkg and bde_cell
`timescale 1ns / 1ps

// channel   direction  signals                                      handshake
// command   in         func, data_value                             start && !busy
// result    out        popped_value, status, entry_count, front_value  done strobe
//
// one operation per cycle: busy stays low, a transaction may follow every cycle
// each result is strobed by done in the cycle after its command is taken
// cost per operation is one shift of the cell chain plus the fill-level compare
// reset clears the fill level and the result strobe; cell contents are not reset
// the receiver cannot stall, results are presented for exactly one cycle

module bounded_deque_engine #(
    parameter int DEPTH = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic [bde_pkg::FUNC_WIDTH-1:0]         func,
    input  logic signed [bde_pkg::FIELD_WIDTH-1:0] data_value,
    output logic                                   done,
    output logic signed [bde_pkg::FIELD_WIDTH-1:0] popped_value,
    output logic [bde_pkg::STATUS_WIDTH-1:0]       status,
    output logic [bde_pkg::COUNT_OUT_WIDTH-1:0]    entry_count,
    output logic signed [bde_pkg::FIELD_WIDTH-1:0] front_value
);
    import bde_pkg::*;

    localparam int SW = VALUE_WIDTH;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int FW = FIELD_WIDTH;
    localparam int OW = COUNT_OUT_WIDTH;

    logic [SW-1:0]           cell_q [DEPTH];
    logic [SW-1:0]           push_val;
    logic [FW-1:0]           front_ext;
    cell_cmd_t               cmd;
    logic                    accept;
    logic                    is_full;
    logic                    is_empty;
    logic [CW-1:0]           count_reg;
    logic [CW-1:0]           count_next;
    logic                    done_reg;
    logic [FW-1:0]           popped_reg;
    logic [FW-1:0]           popped_next;
    logic [STATUS_WIDTH-1:0] status_reg;
    logic [STATUS_WIDTH-1:0] status_next;

    assign busy = 1'b0;
    assign accept = start && !busy;
    assign is_full = (count_reg == CW'(DEPTH));
    assign is_empty = (count_reg == '0);

    // width conversion between port fields and stored entries
    generate
        if (SW <= FW)
        begin : g_narrow
            assign push_val = data_value[SW-1:0];
            assign front_ext = FW'(cell_q[0]);
        end
        else
        begin : g_wide
            assign push_val = {{(SW - FW){1'b0}}, data_value};
            assign front_ext = cell_q[0][FW-1:0];
        end
        if (CW >= OW)
        begin : g_cnt_trunc
            assign entry_count = count_reg[OW-1:0];
        end
        else
        begin : g_cnt_pad
            assign entry_count = {{(OW - CW){1'b0}}, count_reg};
        end
    endgenerate

    // decode the transaction into a qualified cell command and a result
    always_comb
    begin
        cmd = '0;
        count_next = count_reg;
        status_next = ST_OK;
        popped_next = '0;
        if (accept)
        begin
            unique case (func)
                FUNC_PUSH_FRONT, FUNC_PUSH_BACK:
                begin
                    if (is_full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        cmd.push_front = (func == FUNC_PUSH_FRONT);
                        cmd.push_back = (func == FUNC_PUSH_BACK);
                        count_next = count_reg + CW'(1);
                    end
                end
                FUNC_POP_FRONT:
                begin
                    if (is_empty)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        cmd.pop_front = 1'b1;
                        popped_next = front_ext;
                        count_next = count_reg - CW'(1);
                    end
                end
                default:
                begin
                    if (is_empty)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        cmd.rotate = 1'b1;
                    end
                end
            endcase
        end
    end

    // chain of cells, front entry in cell zero
    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic [SW-1:0] left_val;
            logic [SW-1:0] right_val;
            if (gi == 0)
            begin : g_first
                assign left_val = push_val;
            end
            else
            begin : g_mid_l
                assign left_val = cell_q[gi-1];
            end
            if (gi == DEPTH - 1)
            begin : g_last
                assign right_val = cell_q[gi];
            end
            else
            begin : g_mid_r
                assign right_val = cell_q[gi+1];
            end
            bde_cell #(
                .INDEX(gi),
                .SW(SW),
                .CW(CW)
            ) u_cell (
                .clk(clk),
                .cmd(cmd),
                .count(count_reg),
                .push_val(push_val),
                .left_val(left_val),
                .right_val(right_val),
                .front_val(cell_q[0]),
                .q(cell_q[gi])
            );
        end
    endgenerate

    // fill level and result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg <= accept;
        end
    end

    // result payload registers
    always_ff @(posedge clk)
    begin
        popped_reg <= popped_next;
        status_reg <= status_next;
    end

    assign done = done_reg;
    assign popped_value = popped_reg;
    assign status = status_reg;
    assign front_value = is_empty ? '0 : front_ext;

    // fill level never passes the capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("fill level above capacity");

    // push on a full queue reports full and keeps the fill level
    a_full_push: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_full && (func == FUNC_PUSH_FRONT || func == FUNC_PUSH_BACK))
        |=> (done && status == ST_FULL && $stable(count_reg)))
        else $error("full push not rejected");

    // pop or rotate on an empty queue reports empty with zero popped value
    a_empty_op: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_empty && (func == FUNC_POP_FRONT || func == FUNC_ROTATE))
        |=> (done && status == ST_EMPTY && popped_value == '0 && count_reg == '0))
        else $error("empty operation not rejected");

    // successful pop shrinks the queue by one
    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !is_empty && func == FUNC_POP_FRONT)
        |=> (count_reg == $past(count_reg) - CW'(1)))
        else $error("pop did not shrink queue");

endmodule
